// File: rtl/spf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_pkg: shared constants for the smooth point follower
// Default coordinate width, rate register format, unit, snap and reduction limits and operation codes.
// ----------------------------------------------------------------------------
package spf_pkg;

  // Coordinates are signed Q(COORD_BITS-9).8
  localparam int COORD_BITS_DEF = 24;

  // follow_rate register, Q0.16 with one extra integer bit
  localparam int           RATE_W     = 17;
  localparam int           RATE_FRAC  = 16;
  localparam logic [16:0]  RATE_RESET = 17'd6554;

  // One coordinate unit is 256 LSB; a squared distance below 2^16 snaps
  localparam int ONE_UNIT  = 256;
  localparam int SNAP_BITS = 16;

  // Reduced differences are kept below 2^28
  localparam int RED_BITS = 28;

  // Operation codes
  localparam logic OP_SMOOTH = 1'b0;
  localparam logic OP_JUMP   = 1'b1;

endpackage

// File: rtl/smooth_point_follow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smooth_point_follow: moves a stored 2D point toward a goal point
// Smooth moves step along the unit direction by max(rate*distance, 1 unit)
// shifted right by the reduction shift, snapping below one unit; jumps set
// the point to the goal. Bit-serial square, root, multiply and divide loops.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o | op_i, goal_x_i, goal_y_i
//  out     | output    | out_valid_o/out_ready_i | pos_x_o, pos_y_o, snapped_o
//  cfg     | input     | cfg_we_i, no wait       | cfg_wdata_i (follow_rate)
//
//  A jump goes straight to the result state; a snap runs the square loop and
//  the check; a full smooth move runs every loop below in turn.
//  The work is done by one-bit-per-cycle loops: square, root, rate multiply,
//  axis multiply and divide.
//  One item is worked on at a time; in_ready_o is high while idle, also while
//  a finished result waits in the output register.
//  A result that finds the output register still full waits in the last state.
//  Reset clears the point to the origin and follow_rate to 6554 (about 0.1).
//
module smooth_point_follow #(
  parameter int COORD_BITS = spf_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [spf_pkg::RATE_W-1:0]    cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic signed [COORD_BITS-1:0]  goal_x_i,
  input  logic signed [COORD_BITS-1:0]  goal_y_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS-1:0]  pos_x_o,
  output logic signed [COORD_BITS-1:0]  pos_y_o,
  output logic                          snapped_o
);

  import spf_pkg::*;

  // Widths
  localparam int CW   = COORD_BITS;
  localparam int AW   = CW + 1;                          // |difference|
  localparam int RW   = (AW > RED_BITS) ? RED_BITS : AW; // reduced difference
  localparam int SMAX = AW - RW;                         // largest reduction shift
  localparam int SW   = (SMAX > 1) ? $clog2(SMAX + 1) : 1;
  localparam int RTW  = RW + 1;                          // root
  localparam int RMW  = RW + 3;                          // root remainder
  localparam int MW   = 2 * RTW;                         // square / axis product
  localparam int DW   = RTW + SMAX;                      // distance
  localparam int PW   = DW + RATE_W;                     // rate * distance
  localparam int SFW  = PW - RATE_FRAC;                  // unreduced step
  localparam int STW  = RW + 2;                          // reduced step
  localparam int QW   = RW + 2;                          // quotient
  localparam int EW   = ((CW > QW) ? CW : QW) + 2;       // saturating sum
  localparam int CNTW = $clog2(RW + RATE_W);

  // States
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_SQR  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_ROOT = 4'd4;
  localparam logic [3:0] S_RATE = 4'd5;
  localparam logic [3:0] S_STEP = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_DPRE = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  // Control
  logic [3:0]             state_q;
  logic [CNTW-1:0]        cnt_q;
  logic [RATE_W-1:0]      rate_q;
  logic signed [CW-1:0]   cur_x_q, cur_y_q;
  logic                   out_valid_q;

  // Datapath
  logic signed [CW-1:0]   goal_x_q, goal_y_q;
  logic                   snap_q;
  logic                   neg_x_q, neg_y_q;
  logic [SW-1:0]          s_q;
  logic [RW-1:0]          rx_q, ry_q;
  logic [RW-1:0]          mx_q, my_q;     // square multiplier bits, MSB first
  logic [MW-1:0]          acc_x_q, acc_y_q;
  logic [RMW-1:0]         rem_q;
  logic [RTW-1:0]         root_q;
  logic [RATE_W-1:0]      rsh_q;          // rate multiplier bits
  logic [PW-1:0]          prod_q;
  logic [STW-1:0]         stp_q;          // step multiplier bits
  logic [RTW-1:0]         remx_q, remy_q;
  logic signed [CW-1:0]   pos_x_q, pos_y_q;
  logic                   snapped_q;

  // Combinational helpers
  logic signed [AW-1:0]   dx, dy;
  logic [AW-1:0]          ax, ay;
  logic [AW:0]            mag_or;
  logic [SW-1:0]          s_calc;
  logic [MW-1:0]          sqr_next;
  logic [RMW-1:0]         rt_rem, rt_trial;
  logic                   rt_ge;
  logic [DW-1:0]          distance;
  logic [PW-1:0]          prod_next;
  logic [SFW-1:0]         step_full, step_min;
  logic [MW-1:0]          mul_x_next, mul_y_next;
  logic [RTW:0]           dv_x, dv_y, divisor;
  logic                   ge_x, ge_y;
  logic                   snap_now;
  logic                   fin_go;
  logic [CW-1:0]          new_x, new_y;

  // Saturating move of one axis by a magnitude in the sign of the difference
  function automatic logic [CW-1:0] move_axis(input logic [CW-1:0] cur,
                                              input logic           neg,
                                              input logic [QW-1:0]  mag);
    logic [EW-1:0] ext;
    logic [EW-1:0] sum;
    logic          fits;
    begin
      ext  = {{(EW-CW){cur[CW-1]}}, cur};
      sum  = neg ? (ext - EW'(mag)) : (ext + EW'(mag));
      fits = (sum[EW-1:CW-1] == {(EW-CW+1){sum[EW-1]}});
      if (fits) begin
        move_axis = sum[CW-1:0];
      end else if (sum[EW-1]) begin
        move_axis = {1'b1, {(CW-1){1'b0}}};
      end else begin
        move_axis = {1'b0, {(CW-1){1'b1}}};
      end
    end
  endfunction

  always_comb begin
    // differences, magnitudes and the reduction shift
    dx     = AW'(goal_x_q) - AW'(cur_x_q);
    dy     = AW'(goal_y_q) - AW'(cur_y_q);
    ax     = dx[AW-1] ? (~dx + 1'b1) : dx;
    ay     = dy[AW-1] ? (~dy + 1'b1) : dy;
    mag_or = {1'b0, ax | ay};
    s_calc = '0;
    for (int k = 1; k <= SMAX; k++) begin
      if (mag_or[RW-1+k]) begin
        s_calc = SW'(k);
      end
    end

    // square, MSB-first shift and add for both axes
    sqr_next = (acc_x_q << 1)
             + (mx_q[RW-1] ? MW'(rx_q) : '0)
             + (my_q[RW-1] ? MW'(ry_q) : '0);

    // restoring square root, one result bit per cycle
    rt_rem   = {rem_q[RMW-3:0], acc_x_q[MW-1:MW-2]};
    rt_trial = {root_q, 2'b01};
    rt_ge    = (rt_rem >= rt_trial);

    // rate * distance
    distance  = DW'(root_q) << s_q;
    prod_next = (prod_q << 1) + (rsh_q[RATE_W-1] ? PW'(distance) : '0);
    step_full = prod_q[PW-1:RATE_FRAC];
    step_min  = (step_full < SFW'(ONE_UNIT)) ? SFW'(ONE_UNIT) : step_full;

    // axis products
    mul_x_next = (acc_x_q << 1) + (stp_q[STW-1] ? MW'(rx_q) : '0);
    mul_y_next = (acc_y_q << 1) + (stp_q[STW-1] ? MW'(ry_q) : '0);

    // restoring division of both products by the root
    divisor = {1'b0, root_q};
    dv_x    = {remx_q, acc_x_q[QW-1]};
    dv_y    = {remy_q, acc_y_q[QW-1]};
    ge_x    = (dv_x >= divisor);
    ge_y    = (dv_y >= divisor);

    snap_now = (s_q == '0) && (acc_x_q[MW-1:SNAP_BITS] == '0);
    fin_go   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

    if (snap_q) begin
      new_x = goal_x_q;
      new_y = goal_y_q;
    end else begin
      new_x = move_axis(cur_x_q, neg_x_q, acc_x_q[QW-1:0]);
      new_y = move_axis(cur_y_q, neg_y_q, acc_y_q[QW-1:0]);
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign snapped_o   = snapped_q;

  // Sequencer, point and register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rate_q      <= RATE_RESET;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      // a new result refills the output register in the cycle it drains
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= (op_i == OP_JUMP) ? S_FIN : S_PREP;
          end
        end
        S_PREP: begin
          state_q <= S_SQR;
          cnt_q   <= CNTW'(RW - 1);
        end
        S_SQR: begin
          if (cnt_q == '0) begin
            state_q <= S_CHK;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_CHK: begin
          if (snap_now) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_ROOT;
            cnt_q   <= CNTW'(RTW - 1);
          end
        end
        S_ROOT: begin
          if (cnt_q == '0) begin
            state_q <= S_RATE;
            cnt_q   <= CNTW'(RATE_W - 1);
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_RATE: begin
          if (cnt_q == '0) begin
            state_q <= S_STEP;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_STEP: begin
          state_q <= S_MUL;
          cnt_q   <= CNTW'(STW - 1);
        end
        S_MUL: begin
          if (cnt_q == '0) begin
            state_q <= S_DPRE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_DPRE: begin
          state_q <= S_DIV;
          cnt_q   <= CNTW'(QW - 1);
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_FIN;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state_q     <= S_IDLE;
            cur_x_q     <= new_x;
            cur_y_q     <= new_y;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Serial datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          goal_x_q <= goal_x_i;
          goal_y_q <= goal_y_i;
          snap_q   <= (op_i == OP_JUMP);
        end
      end
      S_PREP: begin
        neg_x_q <= dx[AW-1];
        neg_y_q <= dy[AW-1];
        s_q     <= s_calc;
        rx_q    <= RW'(ax >> s_calc);
        ry_q    <= RW'(ay >> s_calc);
        mx_q    <= RW'(ax >> s_calc);
        my_q    <= RW'(ay >> s_calc);
        acc_x_q <= '0;
      end
      S_SQR: begin
        acc_x_q <= sqr_next;
        mx_q    <= mx_q << 1;
        my_q    <= my_q << 1;
      end
      S_CHK: begin
        snap_q <= snap_now;
        rem_q  <= '0;
        root_q <= '0;
        prod_q <= '0;
        rsh_q  <= rate_q;
      end
      S_ROOT: begin
        acc_x_q <= acc_x_q << 2;
        rem_q   <= rt_ge ? (rt_rem - rt_trial) : rt_rem;
        root_q  <= {root_q[RTW-2:0], rt_ge};
      end
      S_RATE: begin
        prod_q <= prod_next;
        rsh_q  <= rsh_q << 1;
      end
      S_STEP: begin
        stp_q   <= STW'(step_min >> s_q);
        acc_x_q <= '0;
        acc_y_q <= '0;
      end
      S_MUL: begin
        acc_x_q <= mul_x_next;
        acc_y_q <= mul_y_next;
        stp_q   <= stp_q << 1;
      end
      S_DPRE: begin
        remx_q <= RTW'(acc_x_q[MW-1:QW]);
        remy_q <= RTW'(acc_y_q[MW-1:QW]);
      end
      S_DIV: begin
        remx_q            <= ge_x ? RTW'(dv_x - divisor) : RTW'(dv_x);
        remy_q            <= ge_y ? RTW'(dv_y - divisor) : RTW'(dv_y);
        acc_x_q[QW-1:0]   <= {acc_x_q[QW-2:0], ge_x};
        acc_y_q[QW-1:0]   <= {acc_y_q[QW-2:0], ge_y};
      end
      S_FIN: begin
        if (fin_go) begin
          pos_x_q   <= new_x;
          pos_y_q   <= new_y;
          snapped_q <= snap_q;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // sum of squares never reaches the top bit of the accumulator
  a_sq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> (acc_x_q[MW-1] == 1'b0))
    else $error("square accumulator overflow");

  // a proportional move always has a distance of at least one unit
  a_root_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DPRE) |-> (root_q >= RTW'(ONE_UNIT)))
    else $error("root below one unit on a proportional move");

  // division remainders stay below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> ((remx_q < root_q) && (remy_q < root_q)))
    else $error("division remainder out of range");

  // moved distance per axis stays below 2^(RW+1), twice the reduced difference range
  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && !snap_q) |-> ((acc_x_q[QW-1] == 1'b0) && (acc_y_q[QW-1] == 1'b0)))
    else $error("axis move magnitude out of range");

  // the stored point changes only when a result is written
  a_cur_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_FIN) |=> ($stable(cur_x_q) && $stable(cur_y_q)))
    else $error("point changed outside result write");
`endif

endmodule
